// ===== rtl/buddy_block_allocator_top_assert.svh =====
// Assertion macros for the buddy block allocator top level
`ifndef BUDDY_BLOCK_ALLOCATOR_TOP_ASSERT_SVH
`define BUDDY_BLOCK_ALLOCATOR_TOP_ASSERT_SVH

// same-cycle implication, sampled on clock, off during reset
`define BBA_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BBA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/bba_pkg.sv =====
// Shared constants, types and helper functions for the buddy block allocator
package bba_pkg;

   localparam int LEVELS = 10;
   localparam int LEAVES = 1 << LEVELS;
   localparam int ADDR_W = LEVELS + 1;
   localparam int DEPTH  = 1 << ADDR_W;
   localparam int SIZE_W = LEVELS + 1;
   localparam int OFF_W  = LEVELS;
   localparam int ORD_W  = $clog2(LEVELS + 2);
   localparam int PAIR_W = LEVELS - 1;

   localparam logic [1:0] KIND_ALLOC   = 2'd0;
   localparam logic [1:0] KIND_FREE    = 2'd1;
   localparam logic [1:0] KIND_REBUILD = 2'd2;
   localparam logic [1:0] KIND_UNUSED  = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_NOFIT = 2'd1;
   localparam logic [1:0] ST_BAD   = 2'd2;

   typedef struct packed {
      logic load;
      logic set_bad;
      logic set_nofit;
      logic init_alloc;
      logic scan_rd;
      logic take;
      logic next_idx;
      logic next_level;
      logic split_l;
      logic split_r;
      logic free_wr;
      logic sweep_wr;
      logic merge_init;
      logic merge_rd;
      logic merge_w0;
      logic merge_w1;
      logic merge_wp;
      logic merge_next;
   } bba_cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       bad_req;
      logic       found;
      logic       idx_last;
      logic       cur_top;
      logic       cur_want;
      logic       node_root;
      logic       both_free;
      logic       pair_last;
      logic       ord_last;
      logic       sweep_last;
   } bba_stat_type;

   // first heap index of the nodes of order k
   function automatic logic [ADDR_W-1:0] level_start(input logic [ORD_W-1:0] k);
      return (ADDR_W'(1) << (ORD_W'(LEVELS) - k)) - ADDR_W'(1);
   endfunction

   // ceil(log2(s)) for s >= 1
   function automatic logic [ORD_W-1:0] order_of(input logic [SIZE_W-1:0] s);
      logic [SIZE_W-1:0] v;
      logic [ORD_W-1:0]  p;
      v = s - SIZE_W'(1);
      p = '0;
      for (int b = 0; b < SIZE_W; b++) begin
         if (v[b]) p = ORD_W'(b + 1);
      end
      return p;
   endfunction

endpackage

// ===== rtl/bba_ram.sv =====
// Generic RAM: one write port, two registered read ports
module bba_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;
endmodule

// ===== rtl/bba_datapath.sv =====
// Datapath: free-bit tree memory, scan/merge/sweep counters and result registers
module bba_datapath
   import bba_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  bba_cmd_type       cmd,
   output bba_stat_type      stat,
   input  logic [1:0]        req_kind,
   input  logic [SIZE_W-1:0] req_size_blocks,
   input  logic [OFF_W-1:0]  req_block_offset,
   input  logic              csr_wr_en,
   input  logic [SIZE_W-1:0] csr_wr_data,
   output logic [1:0]        rsp_status,
   output logic [OFF_W-1:0]  rsp_granted_offset
);
   logic [SIZE_W-1:0] usable_ff;
   logic [SIZE_W-1:0] fill_ff;
   logic [ADDR_W-1:0] sweep_ff;
   logic [1:0]        kind_ff;
   logic [SIZE_W-1:0] size_ff;
   logic [OFF_W-1:0]  off_ff;
   logic [ORD_W-1:0]  want_ff;
   logic [ORD_W-1:0]  cur_ff;
   logic [OFF_W-1:0]  idx_ff;
   logic [ADDR_W-1:0] node_ff;
   logic [ORD_W-1:0]  mord_ff;
   logic [PAIR_W-1:0] pair_ff;
   logic [1:0]        status_ff;
   logic [OFF_W-1:0]  granted_ff;

   logic [ADDR_W-1:0] scan_addr, free_node, buddy, pair_a, sweep_rel;
   logic [ADDR_W-1:0] lvl_cnt_m1, pair_cnt_m1;
   logic              sweep_val;
   logic              wr_en, wr_data;
   logic [ADDR_W-1:0] wr_addr, rd_addr_a;
   logic              rd_a, rd_b;

   assign scan_addr   = level_start(cur_ff) + ADDR_W'(idx_ff);
   assign free_node   = level_start(want_ff) + ADDR_W'(off_ff >> want_ff);
   assign buddy       = free_node[0] ? free_node + ADDR_W'(1) : free_node - ADDR_W'(1);
   assign pair_a      = level_start(mord_ff) + ADDR_W'({pair_ff, 1'b0});
   assign lvl_cnt_m1  = (ADDR_W'(1) << (ORD_W'(LEVELS) - cur_ff)) - ADDR_W'(1);
   assign pair_cnt_m1 = (ADDR_W'(1) << (ORD_W'(LEVELS - 1) - mord_ff)) - ADDR_W'(1);
   assign sweep_rel   = sweep_ff - ADDR_W'(LEAVES - 1);
   assign sweep_val   = (sweep_ff >= ADDR_W'(LEAVES - 1)) && (SIZE_W'(sweep_rel) < fill_ff);

   // one write port: at most one write command per cycle
   always_comb begin
      wr_en   = 1'b1;
      wr_addr = '0;
      wr_data = 1'b0;
      if (cmd.take) begin
         wr_addr = scan_addr;
      end else if (cmd.split_l) begin
         wr_addr = {node_ff[ADDR_W-2:0], 1'b1};
         wr_data = 1'b1;
      end else if (cmd.split_r) begin
         wr_addr = {node_ff[ADDR_W-2:0], 1'b0} + ADDR_W'(2);
         wr_data = 1'b1;
      end else if (cmd.free_wr) begin
         wr_addr = free_node;
         wr_data = 1'b1;
      end else if (cmd.sweep_wr) begin
         wr_addr = sweep_ff;
         wr_data = sweep_val;
      end else if (cmd.merge_w0) begin
         wr_addr = pair_a;
      end else if (cmd.merge_w1) begin
         wr_addr = pair_a + ADDR_W'(1);
      end else if (cmd.merge_wp) begin
         wr_addr = pair_a >> 1;
         wr_data = 1'b1;
      end else begin
         wr_en = 1'b0;
      end
   end

   always_comb begin
      if (cmd.free_wr)       rd_addr_a = buddy;
      else if (cmd.merge_rd) rd_addr_a = pair_a;
      else                   rd_addr_a = scan_addr;
   end

   bba_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_tree (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (rd_a),
      .rd_addr_b (pair_a + ADDR_W'(1)),
      .rd_data_b (rd_b)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         usable_ff <= SIZE_W'(LEAVES);
         fill_ff   <= '0;
         sweep_ff  <= '0;
      end else begin
         if (csr_wr_en) usable_ff <= csr_wr_data;
         if (cmd.load && req_kind == KIND_REBUILD) begin
            fill_ff <= (usable_ff > SIZE_W'(LEAVES)) ? SIZE_W'(LEAVES) : usable_ff;
         end
         if (cmd.sweep_wr) sweep_ff <= sweep_ff + ADDR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff    <= req_kind;
         size_ff    <= req_size_blocks;
         off_ff     <= req_block_offset;
         want_ff    <= order_of(req_size_blocks);
         status_ff  <= ST_OK;
         granted_ff <= '0;
      end
      if (cmd.set_bad)   status_ff <= ST_BAD;
      if (cmd.set_nofit) status_ff <= ST_NOFIT;
      if (cmd.init_alloc) begin
         cur_ff <= want_ff;
         idx_ff <= '0;
      end
      if (cmd.take) begin
         node_ff <= scan_addr;
         if (cur_ff == want_ff) granted_ff <= idx_ff << want_ff;
      end
      if (cmd.next_idx) idx_ff <= idx_ff + OFF_W'(1);
      if (cmd.next_level) begin
         cur_ff <= cur_ff + ORD_W'(1);
         idx_ff <= '0;
      end
      if (cmd.split_r) begin
         cur_ff <= cur_ff - ORD_W'(1);
         idx_ff <= '0;
      end
      if (cmd.merge_init) begin
         mord_ff <= '0;
         pair_ff <= '0;
      end
      if (cmd.merge_next) begin
         if (ADDR_W'(pair_ff) == pair_cnt_m1) begin
            mord_ff <= mord_ff + ORD_W'(1);
            pair_ff <= '0;
         end else begin
            pair_ff <= pair_ff + PAIR_W'(1);
         end
      end
   end

   always_comb begin
      stat.kind       = kind_ff;
      stat.bad_req    = (kind_ff == KIND_UNUSED) ||
                        (kind_ff != KIND_REBUILD &&
                         (size_ff == '0 || size_ff > SIZE_W'(LEAVES)));
      stat.found      = rd_a;
      stat.idx_last   = ADDR_W'(idx_ff) == lvl_cnt_m1;
      stat.cur_top    = cur_ff == ORD_W'(LEVELS);
      stat.cur_want   = cur_ff == want_ff;
      stat.node_root  = free_node == '0;
      stat.both_free  = rd_a & rd_b;
      stat.pair_last  = ADDR_W'(pair_ff) == pair_cnt_m1;
      stat.ord_last   = mord_ff == ORD_W'(LEVELS - 1);
      stat.sweep_last = &sweep_ff;
   end

   assign rsp_status         = status_ff;
   assign rsp_granted_offset = granted_ff;
endmodule

// ===== rtl/bba_ctrl.sv =====
// Controller state machine: sequences allocation scans, frees, merges and sweeps
module bba_ctrl
   import bba_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   output logic         rsp_valid,
   input  bba_stat_type stat,
   output bba_cmd_type  cmd
);
   localparam logic [3:0] S_INIT  = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_DEC   = 4'd2;
   localparam logic [3:0] S_ARD   = 4'd3;
   localparam logic [3:0] S_ACHK  = 4'd4;
   localparam logic [3:0] S_ASPL  = 4'd5;
   localparam logic [3:0] S_ASPR  = 4'd6;
   localparam logic [3:0] S_FWR   = 4'd7;
   localparam logic [3:0] S_FCHK  = 4'd8;
   localparam logic [3:0] S_SWEEP = 4'd9;
   localparam logic [3:0] S_MRD   = 4'd10;
   localparam logic [3:0] S_MCHK  = 4'd11;
   localparam logic [3:0] S_MW1   = 4'd12;
   localparam logic [3:0] S_MW2   = 4'd13;
   localparam logic [3:0] S_RESP  = 4'd14;

   logic [3:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_INIT;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_INIT: begin
            // power-up clearing pass over the whole tree
            cmd.sweep_wr = 1'b1;
            if (stat.sweep_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            if (stat.bad_req) begin
               cmd.set_bad = 1'b1;
               state_in    = S_RESP;
            end else if (stat.kind == KIND_ALLOC) begin
               cmd.init_alloc = 1'b1;
               state_in       = S_ARD;
            end else if (stat.kind == KIND_FREE) begin
               state_in = S_FWR;
            end else begin
               state_in = S_SWEEP;
            end
         end
         S_ARD: begin
            cmd.scan_rd = 1'b1;
            state_in    = S_ACHK;
         end
         S_ACHK: begin
            if (stat.found) begin
               cmd.take = 1'b1;
               state_in = stat.cur_want ? S_RESP : S_ASPL;
            end else if (!stat.idx_last) begin
               cmd.next_idx = 1'b1;
               state_in     = S_ARD;
            end else if (stat.cur_top) begin
               cmd.set_nofit = 1'b1;
               state_in      = S_RESP;
            end else begin
               cmd.next_level = 1'b1;
               state_in       = S_ARD;
            end
         end
         S_ASPL: begin
            cmd.split_l = 1'b1;
            state_in    = S_ASPR;
         end
         S_ASPR: begin
            cmd.split_r = 1'b1;
            state_in    = S_ARD;
         end
         S_FWR: begin
            // mark the node free and fetch its buddy in the same cycle
            cmd.free_wr = 1'b1;
            state_in    = stat.node_root ? S_RESP : S_FCHK;
         end
         S_FCHK: begin
            if (stat.found) begin
               cmd.merge_init = 1'b1;
               state_in       = S_MRD;
            end else begin
               state_in = S_RESP;
            end
         end
         S_SWEEP: begin
            cmd.sweep_wr = 1'b1;
            if (stat.sweep_last) begin
               cmd.merge_init = 1'b1;
               state_in       = S_MRD;
            end
         end
         S_MRD: begin
            cmd.merge_rd = 1'b1;
            state_in     = S_MCHK;
         end
         S_MCHK: begin
            if (stat.both_free) begin
               cmd.merge_w0 = 1'b1;
               state_in     = S_MW1;
            end else begin
               cmd.merge_next = 1'b1;
               state_in = (stat.pair_last && stat.ord_last) ? S_RESP : S_MRD;
            end
         end
         S_MW1: begin
            cmd.merge_w1 = 1'b1;
            state_in     = S_MW2;
         end
         S_MW2: begin
            cmd.merge_wp   = 1'b1;
            cmd.merge_next = 1'b1;
            state_in = (stat.pair_last && stat.ord_last) ? S_RESP : S_MRD;
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy      = state_ff != S_IDLE;
   assign rsp_valid = state_ff == S_RESP;
endmodule

// ===== rtl/buddy_block_allocator_top.sv =====
// Top level of the buddy block allocator: controller, datapath and checks
//
// Binary buddy allocator over 1024 blocks, one free bit per tree node in a
// 2048 x 1 RAM. After reset the block runs a clearing pass over every node with
// busy high. A request is taken when start is high and busy low; exactly one
// result strobes on rsp_valid for one cycle and cannot be held off. Every
// request is one tree-RAM access per step: an allocation scans nodes level by
// level from the wanted order upward and splits the block it takes down to the
// wanted order; a free marks its node free and, unless it is the whole region,
// checks the buddy, running the merge sweep over all 1023 pairs when the buddy
// is free; a rebuild sweeps the tree, then runs the merge sweep. usable_blocks may be written only
// while busy is low.
module buddy_block_allocator_top
   import bba_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_kind,
   input  logic [SIZE_W-1:0] req_size_blocks,
   input  logic [OFF_W-1:0]  req_block_offset,
   output logic              rsp_valid,
   output logic [1:0]        rsp_status,
   output logic [OFF_W-1:0]  rsp_granted_offset,
   input  logic              csr_wr_en,
   input  logic [SIZE_W-1:0] csr_wr_data
);
`include "buddy_block_allocator_top_assert.svh"

   bba_cmd_type  cmd;
   bba_stat_type stat;

   bba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .stat      (stat),
      .cmd       (cmd)
   );

   bba_datapath u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_kind           (req_kind),
      .req_size_blocks    (req_size_blocks),
      .req_block_offset   (req_block_offset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .rsp_status         (rsp_status),
      .rsp_granted_offset (rsp_granted_offset)
   );

   `BBA_ASSERT_NEXT(a_one_strobe, rsp_valid, !rsp_valid && !busy, "result strobe not single")
   `BBA_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !rsp_valid, "transfer not taken")
   `BBA_ASSERT_NOW(a_grant_ok, rsp_valid && rsp_granted_offset != '0,
                   rsp_status == ST_OK, "offset on failed result")
   `BBA_ASSERT_NOW(a_status_code, rsp_valid, rsp_status <= ST_BAD, "bad status code")
endmodule

// ===== tb/buddy_block_allocator_top_tb.sv =====
// Self-checking testbench for the buddy block allocator top level
`timescale 1ns / 100ps

module buddy_block_allocator_top_tb
   import bba_pkg::*;
();

   typedef struct packed {
      logic [1:0]       status;
      logic [OFF_W-1:0] granted;
   } alloc_result_type;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic [1:0]        req_kind;
   logic [SIZE_W-1:0] req_size_blocks;
   logic [OFF_W-1:0]  req_block_offset;
   logic              rsp_valid;
   logic [1:0]        rsp_status;
   logic [OFF_W-1:0]  rsp_granted_offset;
   logic              csr_wr_en;
   logic [SIZE_W-1:0] csr_wr_data;

   bit                model_tree [DEPTH];
   int unsigned       model_usable;
   alloc_result_type  pending_results [$];
   int                fail_count;
   int                gap_pct;
   // offsets and orders of live allocations, so frees are mostly well formed
   int unsigned       live_off [$];
   int unsigned       live_ord [$];

   buddy_block_allocator_top uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_size_blocks(req_size_blocks),
      .req_block_offset(req_block_offset), .rsp_valid(rsp_valid),
      .rsp_status(rsp_status), .rsp_granted_offset(rsp_granted_offset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int unsigned first_node(int unsigned k);
      return (1 << (LEVELS - k)) - 1;
   endfunction

   function automatic int unsigned size_order(int unsigned s);
      int unsigned p;
      p = 0;
      while ((1 << p) < s) p++;
      return p;
   endfunction

   function automatic void merge_pairs();
      int unsigned a;
      for (int k = 0; k < LEVELS; k++) begin
         for (int p = 0; p < (1 << (LEVELS - k - 1)); p++) begin
            a = first_node(k) + 2 * p;
            if (model_tree[a] && model_tree[a + 1]) begin
               model_tree[a] = 0;
               model_tree[a + 1] = 0;
               model_tree[a / 2] = 1;
            end
         end
      end
   endfunction

   function automatic alloc_result_type predict_alloc(logic [1:0] kind,
         int unsigned size, int unsigned offs);
      alloc_result_type r;
      int unsigned want, cur, n, node, lim;
      bit found;
      r = '0;
      if (kind == KIND_ALLOC || kind == KIND_FREE) begin
         if (size == 0 || size > LEAVES) begin
            r.status = ST_BAD;
         end else if (kind == KIND_ALLOC) begin
            want = size_order(size);
            cur = want;
            r.status = ST_NOFIT;
            while (cur <= LEVELS && r.status == ST_NOFIT) begin
               found = 0;
               for (int i = 0; i < (1 << (LEVELS - cur)); i++) begin
                  n = first_node(cur) + i;
                  if (model_tree[n]) begin
                     model_tree[n] = 0;
                     if (cur == want) begin
                        r.status = ST_OK;
                        r.granted = OFF_W'(i << want);
                     end else begin
                        model_tree[2 * n + 1] = 1;
                        model_tree[2 * n + 2] = 1;
                        cur--;
                     end
                     found = 1;
                     break;
                  end
               end
               if (!found) cur++;
            end
         end else begin
            want = size_order(size);
            node = first_node(want) + ((offs >> want) & ((1 << (LEVELS - want)) - 1));
            model_tree[node] = 1;
            if (node != 0) begin
               n = (node & 1) ? node + 1 : node - 1;
               if (model_tree[n]) merge_pairs();
            end
         end
      end else if (kind == KIND_REBUILD) begin
         for (int i = 0; i < DEPTH; i++) model_tree[i] = 0;
         lim = model_usable > LEAVES ? LEAVES : model_usable;
         for (int i = 0; i < lim; i++) model_tree[LEAVES - 1 + i] = 1;
         merge_pairs();
      end else begin
         r.status = ST_BAD;
      end
      return r;
   endfunction

   task automatic send_request(logic [1:0] kind, int unsigned size, int unsigned offs);
      alloc_result_type r;
      // step to a fresh falling edge so start is never driven twice in one step
      @(negedge clock);
      while ($urandom_range(99) < gap_pct) @(negedge clock);
      req_kind <= kind;
      req_size_blocks <= SIZE_W'(size);
      req_block_offset <= OFF_W'(offs);
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      r = predict_alloc(kind, size, offs);
      pending_results.push_back(r);
      if (kind == KIND_ALLOC && r.status == ST_OK) begin
         live_off.push_back(r.granted);
         live_ord.push_back(size_order(size));
      end
      if (kind == KIND_REBUILD) begin
         live_off.delete();
         live_ord.delete();
      end
      @(negedge clock);
      start <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      while (busy) @(negedge clock);
   endtask

   task automatic write_usable(int unsigned v);
      wait_drained();
      csr_wr_en <= 1'b1;
      csr_wr_data <= SIZE_W'(v);
      model_usable = v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   always @(posedge clock) begin
      alloc_result_type e;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result status %0d offset %0d", $time,
                     rsp_status, rsp_granted_offset);
            fail_count++;
         end else begin
            e = pending_results.pop_front();
            if (rsp_status !== e.status) begin
               $display("%0t: status expected %0d actual %0d", $time, e.status, rsp_status);
               fail_count++;
            end
            if (rsp_granted_offset !== e.granted) begin
               $display("%0t: offset expected %0d actual %0d", $time, e.granted,
                        rsp_granted_offset);
               fail_count++;
            end
         end
      end
   end

   task automatic test_directed();
      send_request(KIND_ALLOC, 1, 0);        // empty tree: no fit
      send_request(KIND_REBUILD, 0, 0);
      send_request(KIND_ALLOC, 1024, 0);
      send_request(KIND_ALLOC, 1, 0);
      send_request(KIND_FREE, 1024, 0);      // whole region, no buddy
      send_request(KIND_ALLOC, 0, 0);        // bad sizes
      send_request(KIND_ALLOC, 1025, 0);
      send_request(KIND_FREE, 2047, 1023);
      send_request(KIND_FREE, 0, 5);
      send_request(KIND_UNUSED, 3, 7);       // unused kind
      send_request(KIND_ALLOC, 3, 0);
      send_request(KIND_ALLOC, 1, 0);
      send_request(KIND_FREE, 4, 1023);      // unaligned
      send_request(KIND_FREE, 1, 1023);      // double/unallocated free
      send_request(KIND_FREE, 1, 1022);
      send_request(KIND_ALLOC, 512, 0);
      send_request(KIND_ALLOC, 600, 0);
      write_usable(1);
      send_request(KIND_REBUILD, 0, 0);
      send_request(KIND_ALLOC, 1, 0);
      send_request(KIND_ALLOC, 1, 0);
      write_usable(2047);                    // above capacity marks all
      send_request(KIND_REBUILD, 0, 0);
      write_usable(0);
      send_request(KIND_REBUILD, 0, 0);
      send_request(KIND_ALLOC, 1, 0);
   endtask

   task automatic test_random(int n);
      int unsigned pick, idx, sz;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(99);
         sz = ($urandom_range(9) == 0) ? $urandom_range(1024) : $urandom_range(1, 40);
         if (pick < 50) begin
            send_request(KIND_ALLOC, sz, $urandom);
         end else if (pick < 88 && live_off.size() != 0) begin
            idx = $urandom_range(live_off.size() - 1);
            send_request(KIND_FREE, 1 << live_ord[idx], live_off[idx]);
            live_off.delete(idx);
            live_ord.delete(idx);
         end else if (pick < 95) begin
            send_request(KIND_FREE, $urandom_range(2047), $urandom);
         end else if (pick < 97) begin
            send_request(KIND_UNUSED, $urandom_range(2047), $urandom);
         end else begin
            write_usable($urandom_range(2) == 0 ? $urandom_range(2047)
                                                : $urandom_range(1, 1024));
            send_request(KIND_REBUILD, $urandom_range(2047), $urandom);
         end
      end
   endtask

   task automatic test_drain_pause();
      wait_drained();
      send_request(KIND_ALLOC, 1, 0);
   endtask

   initial begin
      fail_count = 0;
      gap_pct = 10;
      model_usable = 1024;
      for (int i = 0; i < DEPTH; i++) model_tree[i] = 0;
      reset = 1'b1;
      start = 1'b0;
      req_kind = KIND_ALLOC;
      req_size_blocks = '0;
      req_block_offset = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      write_usable(1024);
      test_directed();
      write_usable(1024);
      send_request(KIND_REBUILD, 0, 0);
      test_random(500);
      gap_pct = 48;
      test_drain_pause();
      test_random(500);
      gap_pct = 0;
      test_random(525);
      wait_drained();
      repeat (50) @(negedge clock);
      if (fail_count == 0 && pending_results.size() == 0)
         $display("buddy_block_allocator_top verification clean");
      else
         $display("buddy_block_allocator_top verification failed");
      $finish;
   end

   initial begin
      #1000ms;
      $display("buddy_block_allocator_top verification failed");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/bba_pkg.sv
rtl/bba_ram.sv
rtl/bba_datapath.sv
rtl/bba_ctrl.sv
rtl/buddy_block_allocator_top.sv
tb/buddy_block_allocator_top_tb.sv
